@@ rtl/iiel_pkg.sv @@
// ----------------------------------------------------------------------------
// iiel_pkg
// shared types and constants of the indexed insert/erase list unit
// ----------------------------------------------------------------------------
package iiel_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK = 3'd0,
        CMD_POP_BACK  = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_ERASE     = 3'd3,
        CMD_READ_AT   = 3'd4,
        CMD_FRONT     = 3'd5,
        CMD_BACK      = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

endpackage

@@ rtl/iiel_req_if.sv @@
// ----------------------------------------------------------------------------
// iiel_req_if
// command channel: valid/ready handshake with command, position and value
// ----------------------------------------------------------------------------
interface iiel_req_if;

    logic                            valid;
    logic                            ready;
    logic [iiel_pkg::CMD_W-1:0]      command;
    logic [iiel_pkg::POS_W-1:0]      position;
    logic [iiel_pkg::VALUE_W-1:0]    element_value;

    modport source (
        output valid,
        output command,
        output position,
        output element_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  position,
        input  element_value,
        output ready
    );

endinterface

@@ rtl/iiel_rsp_if.sv @@
// ----------------------------------------------------------------------------
// iiel_rsp_if
// result channel: valid/ready handshake with read value, count and status
// ----------------------------------------------------------------------------
interface iiel_rsp_if;

    logic                            valid;
    logic                            ready;
    logic [iiel_pkg::VALUE_W-1:0]    read_value;
    logic [iiel_pkg::COUNT_W-1:0]    element_count;
    logic                            is_empty;
    logic [iiel_pkg::STAT_W-1:0]     status;

    modport source (
        output valid,
        output read_value,
        output element_count,
        output is_empty,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_value,
        input  element_count,
        input  is_empty,
        input  status,
        output ready
    );

endinterface

@@ rtl/iiel_cell.sv @@
// ----------------------------------------------------------------------------
// iiel_cell
// one list slot: holds, loads a new value, or takes a neighbor's value
// ----------------------------------------------------------------------------
module iiel_cell #(
    parameter int DATA_WIDTH = iiel_pkg::DATA_WIDTH_DEF,
    parameter int CMP_W      = iiel_pkg::POS_W,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  iiel_pkg::cell_op_t    op,
    input  logic [CMP_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            iiel_pkg::CELL_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = wr_data;
                end
                else if (MY_IDX > pos)
                begin
                    data_next = left_data;
                end
            end
            iiel_pkg::CELL_ERASE:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/indexed_insert_erase_list_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit
// fixed-capacity ordered list built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   req channel takes one command word: push back, pop back, insert before
//   a position, erase at a position, read at a position, front or back
//   rsp channel returns one word per command: read value, element count,
//   empty flag and status (ok, out of range, full, empty)
//   a failing command leaves the list unchanged and reports the reason
// timing
//   a result word appears in the cycle after its command word is taken
//   one command word per cycle while rsp.ready holds; every cell shifts in
//   the same cycle, so insert and erase cost no more than a push
// reset
//   rst_n clears the element count and the result valid; slot contents
//   are not cleared and are only read after being written
// stall
//   while a result word waits unaccepted, req.ready stays low; no word
//   is lost or repeated
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit #(
    parameter int LIST_DEPTH = iiel_pkg::LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = iiel_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    iiel_req_if.sink   req,
    iiel_rsp_if.source rsp
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > iiel_pkg::POS_W) ? CNT_W : iiel_pkg::POS_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [iiel_pkg::VALUE_W-1:0] rd_value_reg;
    logic [iiel_pkg::VALUE_W-1:0] rd_value_next;
    iiel_pkg::status_t           status_reg;
    iiel_pkg::status_t           status_next;

    logic                        accept;
    iiel_pkg::cmd_t              cmd;
    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            cnt_ext;
    logic [DATA_WIDTH-1:0]       wr_data;
    logic [CNT_W-1:0]            cnt_new;
    iiel_pkg::cell_op_t          op_new;
    iiel_pkg::cell_op_t          cell_op;
    logic [CMP_W-1:0]            cell_pos;
    iiel_pkg::status_t           status_new;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_idx;
    logic [DATA_WIDTH-1:0]       rd_data;
    logic [DATA_WIDTH-1:0]       cell_data [LIST_DEPTH];

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign cmd       = iiel_pkg::cmd_t'(req.command);
    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign wr_data   = DATA_WIDTH'(req.element_value);

    // command decode
    always_comb
    begin
        cnt_new    = count_reg;
        op_new     = iiel_pkg::CELL_HOLD;
        cell_pos   = pos_ext;
        status_new = iiel_pkg::ST_OK;
        rd_en      = 1'b0;
        rd_idx     = IDX_W'(pos_ext);
        case (cmd)
            iiel_pkg::CMD_PUSH_BACK:
            begin
                if (cnt_ext >= DEPTH_C)
                begin
                    status_new = iiel_pkg::ST_FULL;
                end
                else
                begin
                    op_new   = iiel_pkg::CELL_INSERT;
                    cell_pos = cnt_ext;
                    cnt_new  = CNT_W'(count_reg + 1'b1);
                end
            end
            iiel_pkg::CMD_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    status_new = iiel_pkg::ST_EMPTY;
                end
                else
                begin
                    cnt_new = CNT_W'(count_reg - 1'b1);
                end
            end
            iiel_pkg::CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status_new = iiel_pkg::ST_RANGE;
                end
                else if (cnt_ext >= DEPTH_C)
                begin
                    status_new = iiel_pkg::ST_FULL;
                end
                else
                begin
                    op_new  = iiel_pkg::CELL_INSERT;
                    cnt_new = CNT_W'(count_reg + 1'b1);
                end
            end
            iiel_pkg::CMD_ERASE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_new = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    op_new  = iiel_pkg::CELL_ERASE;
                    cnt_new = CNT_W'(count_reg - 1'b1);
                end
            end
            iiel_pkg::CMD_READ_AT:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_new = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            iiel_pkg::CMD_FRONT:
            begin
                rd_idx = '0;
                if (count_reg == '0)
                begin
                    status_new = iiel_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            iiel_pkg::CMD_BACK:
            begin
                rd_idx = IDX_W'(count_reg - 1'b1);
                if (count_reg == '0)
                begin
                    status_new = iiel_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                status_new = iiel_pkg::ST_OK;
            end
        endcase
    end

    assign rd_data = cell_data[rd_idx];

    assign cell_op = accept ? op_new : iiel_pkg::CELL_HOLD;

    // row of cells
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == LIST_DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        iiel_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (g)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // result word register
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        rd_value_next  = rd_value_reg;
        status_next    = status_reg;
        if (accept)
        begin
            count_next     = cnt_new;
            out_valid_next = 1'b1;
            rd_value_next  = rd_en ? iiel_pkg::VALUE_W'(rd_data) : '0;
            status_next    = status_new;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_value_reg <= rd_value_next;
        status_reg   <= status_next;
    end

    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;

    assign out_count_next = accept ? cnt_new : out_count_reg;

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_value    = rd_value_reg;
    assign rsp.element_count = iiel_pkg::COUNT_W'(out_count_reg);
    assign rsp.is_empty      = (out_count_reg == '0);
    assign rsp.status        = status_reg;

endmodule

@@ tb/list_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_result_checker
// watches the command and result channels of the list unit, keeps its own
// copy of the list contents and compares every result word, field by field,
// against the oldest predicted result
// ----------------------------------------------------------------------------
module list_result_checker
    import iiel_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iiel_req_if                req,
    iiel_rsp_if                rsp,
    output int                 fail_count,
    output int                 outstanding,
    output logic [COUNT_W-1:0] held_count
);

    localparam int DEPTH      = LIST_DEPTH_DEF;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] element_count;
        logic               is_empty;
        status_t            status;
    } list_result_t;

    logic [VALUE_W-1:0] slots [DEPTH];
    int                 list_len;
    int                 errs;
    list_result_t       predicted_results [$];

    function automatic list_result_t apply_command(
        input logic [CMD_W-1:0]   code,
        input logic [POS_W-1:0]   pos,
        input logic [VALUE_W-1:0] value
    );
        list_result_t r;
        int           i;
        r.read_value = '0;
        r.status     = ST_OK;
        case (cmd_t'(code))
            CMD_PUSH_BACK:
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slots[list_len] = value;
                    list_len++;
                end
            CMD_POP_BACK:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len--;
            CMD_INSERT:
                if (int'(pos) > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        slots[i] = slots[i-1];
                    slots[pos] = value;
                    list_len++;
                end
            CMD_ERASE:
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        slots[i] = slots[i+1];
                    list_len--;
                end
            CMD_READ_AT:
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = slots[pos];
            CMD_FRONT:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.read_value = slots[0];
            CMD_BACK:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.read_value = slots[list_len-1];
            default:
                ;
        endcase
        r.element_count = COUNT_W'(list_len);
        r.is_empty      = (list_len == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (errs < REPORT_CAP)
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        list_result_t pred;
        if (!rst_n)
        begin
            list_len = 0;
            errs     = 0;
            predicted_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
            held_count  <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (errs < REPORT_CAP)
                        $display("%0t: result word with nothing expected: %s %0h %0d %0d %0d",
                                 $time, "expected none, got", rsp.read_value,
                                 rsp.element_count, rsp.is_empty, rsp.status);
                    errs++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("read_value", 32'(want.read_value), 32'(rsp.read_value));
                    check_field("element_count", 32'(want.element_count),
                                32'(rsp.element_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                    check_field("status", 32'(want.status), 32'(rsp.status));
                end
            end
            if (req.valid && req.ready)
            begin
                pred = apply_command(req.command, req.position, req.element_value);
                predicted_results.insert(predicted_results.size(), pred);
            end
            fail_count  <= errs;
            outstanding <= predicted_results.size();
            held_count  <= COUNT_W'(list_len);
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives command words into the list unit with random gaps and result
// stalls: a directed opening over empty, range and edge cases, then random
// phases that fill, drain or churn the list; the checker gives the verdict
// ----------------------------------------------------------------------------
module tb;
    import iiel_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;
    localparam int               RANDOM_WORDS = 1600;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_CHURN
    } phase_mode_t;

    logic               clk;
    logic               rst_n;
    int                 fail_count;
    int                 outstanding;
    logic [COUNT_W-1:0] held_count;
    int                 send_quiet;
    int                 take_quiet;

    iiel_req_if req ();
    iiel_rsp_if rsp ();

    indexed_insert_erase_list_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    list_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .held_count  (held_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // idle cycles before a word, with runs of back-to-back words
    function automatic int draw_idle(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] code, input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_idle(send_quiet);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.command       <= code;
        req.position      <= pos;
        req.element_value <= value;
        do @(posedge clk); while (!req.ready);
    endtask

    // result side
    initial
    begin
        int stall;
        take_quiet = 0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_idle(take_quiet);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    // command side
    initial
    begin
        phase_mode_t      mode;
        int               phase_left;
        int               roll;
        int               n;
        logic [CMD_W-1:0] code;
        logic [POS_W-1:0] pos;
        logic [VALUE_W-1:0] value;

        send_quiet        = 0;
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.command       <= CMD_PUSH_BACK;
        req.position      <= '0;
        req.element_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty list
        send_word(CMD_POP_BACK, 7'd0, 32'h0);
        send_word(CMD_FRONT, 7'd0, 32'h0);
        send_word(CMD_BACK, 7'd0, 32'h0);
        send_word(CMD_ERASE, 7'd0, 32'h0);
        send_word(CMD_READ_AT, 7'd0, 32'h0);
        send_word(CMD_INSERT, 7'd1, 32'h1234_5678);
        // insert at the end of an empty list, then middle and append by insert
        send_word(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_word(CMD_PUSH_BACK, 7'd0, 32'h0000_0000);
        send_word(CMD_INSERT, 7'd1, 32'hA5A5_5A5A);
        send_word(CMD_INSERT, 7'd3, 32'h8000_0001);
        send_word(CMD_READ_AT, 7'd0, 32'h0);
        send_word(CMD_READ_AT, 7'd3, 32'h0);
        send_word(CMD_READ_AT, 7'd4, 32'h0);
        send_word(CMD_READ_AT, 7'd64, 32'h0);
        send_word(CMD_FRONT, 7'd0, 32'h0);
        send_word(CMD_BACK, 7'd0, 32'h0);
        send_word(CMD_INSERT, 7'd64, 32'h5A5A_A5A5);
        send_word(CMD_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_word(CMD_ERASE, 7'd1, 32'h0);
        send_word(CMD_ERASE, 7'd2, 32'h0);
        send_word(CMD_ERASE, 7'd3, 32'h0);
        send_word(CMD_ERASE, 7'd0, 32'h0);
        send_word(CMD_POP_BACK, 7'd0, 32'h0);
        send_word(CMD_POP_BACK, 7'd0, 32'h0);

        phase_left = 0;
        mode       = PHASE_FILL;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = phase_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;

            roll = $urandom_range(0, 99);
            case (mode)
                PHASE_FILL:
                    code = roll < 35 ? CMD_PUSH_BACK :
                           roll < 70 ? CMD_INSERT    :
                           roll < 77 ? CMD_READ_AT   :
                           roll < 84 ? CMD_FRONT     :
                           roll < 90 ? CMD_BACK      :
                           roll < 95 ? CMD_POP_BACK  : CMD_ERASE;
                PHASE_DRAIN:
                    code = roll < 35 ? CMD_POP_BACK  :
                           roll < 70 ? CMD_ERASE     :
                           roll < 77 ? CMD_READ_AT   :
                           roll < 84 ? CMD_FRONT     :
                           roll < 90 ? CMD_BACK      :
                           roll < 95 ? CMD_PUSH_BACK : CMD_INSERT;
                default:
                    code = roll == 0 ? CMD_UNUSED : CMD_W'($urandom_range(0, 6));
            endcase

            // positions mostly at or below the current fill level
            roll = $urandom_range(0, 99);
            if (roll < 70)
                pos = POS_W'($urandom_range(0, held_count));
            else if (roll < 85)
                pos = (roll[0] || held_count == 0) ? held_count : held_count - 1'b1;
            else
                pos = POS_W'($urandom_range(0, 64));

            roll = $urandom_range(0, 99);
            if (roll < 4)
                value = '0;
            else if (roll < 8)
                value = '1;
            else if (roll < 12)
                value = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
            else
                value = $urandom;

            send_word(code, pos, value);
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
